// ----- rtl/tkpq_pkg.sv -----
// Shared types, constants and the ordering function for the two-key priority queue.
// No dependencies; used by tkpq_cell and two_key_priority_queue_top.
`timescale 1ns / 1ps
`default_nettype none

package tkpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W       = 5;

   localparam logic       CMD_INSERT   = 1'b0;
   localparam logic       CMD_POP      = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  pri;
      logic [6:0]  sec;
      logic [4:0]  hh;
      logic [5:0]  mm;
      logic [5:0]  ss;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   // Broadcast to every cell: what the row does in this cycle.
   typedef struct packed {
      logic      ins;
      logic      pop;
      entry_type entry;
   } op_type;

   // True when new entry n must go ahead of stored entry s.
   function automatic logic goes_before(input entry_type n, input entry_type s);
      goes_before = (s.pri < n.pri) || ((s.pri == n.pri) && (s.sec < n.sec));
   endfunction

endpackage

`default_nettype wire

// ----- rtl/tkpq_cell.sv -----
// One slot of the sorted row: holds an entry and its valid bit.
// Depends on tkpq_pkg; instantiated QUEUE_DEPTH times by two_key_priority_queue_top.
`timescale 1ns / 1ps
`default_nettype none

module tkpq_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tkpq_pkg::op_type   op,
   input  wire tkpq_pkg::slot_type left_slot,
   input  wire logic              left_before,
   input  wire tkpq_pkg::slot_type right_slot,
   output      tkpq_pkg::slot_type slot,
   output      logic              goes_ahead
);

   logic                valid_ff, valid_in;
   tkpq_pkg::entry_type entry_ff, entry_in;

   // An empty cell always yields to the new entry; the row stays a prefix of valid cells.
   assign goes_ahead = !valid_ff || tkpq_pkg::goes_before(op.entry, entry_ff);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (op.ins && goes_ahead) begin
         // shift right from the insertion point, take the new entry at it
         if (left_before) begin
            valid_in = left_slot.valid;
            entry_in = left_slot.entry;
         end else begin
            valid_in = 1'b1;
            entry_in = op.entry;
         end
      end else if (op.pop) begin
         valid_in = right_slot.valid;
         entry_in = right_slot.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign slot.valid = valid_ff;
   assign slot.entry = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/two_key_priority_queue_top.sv -----
// Top level of the two-key priority queue: a row of tkpq_cell slots kept in sorted order.
// Depends on tkpq_pkg and tkpq_cell.
//
//   channel | ports                  | transfer
//   --------+------------------------+---------------------------------------------
//   request | start, busy, req_*     | clock edge with start high and busy low
//   result  | rsp_strobe, rsp_*      | clock edge ending the one cycle strobe is high
//
// One item per cycle: every cell compares the new entry with its own in parallel and
// shifts in the same cycle, so busy stays low. The result appears in the cycle after
// the request transfer, for one cycle. Synchronous reset empties every slot and clears
// the count; no clearing pass follows. The receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none

module two_key_priority_queue_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic        req_command,
   input  wire logic [15:0] req_entry_id,
   input  wire logic [3:0]  req_primary_key,
   input  wire logic [6:0]  req_secondary_key,
   input  wire logic [4:0]  req_arrival_hour,
   input  wire logic [5:0]  req_arrival_minute,
   input  wire logic [5:0]  req_arrival_second,
   output      logic        rsp_strobe,
   output      logic        rsp_popped_valid,
   output      logic [15:0] rsp_out_id,
   output      logic [3:0]  rsp_out_primary,
   output      logic [6:0]  rsp_out_secondary,
   output      logic [4:0]  rsp_out_hour,
   output      logic [5:0]  rsp_out_minute,
   output      logic [5:0]  rsp_out_second,
   output      logic [4:0]  rsp_occupancy,
   output      logic [1:0]  rsp_status
);

   localparam int DEPTH = tkpq_pkg::QUEUE_DEPTH;

   tkpq_pkg::slot_type                  slot_vec   [DEPTH];
   logic               [DEPTH-1:0]      before_vec;
   logic               [DEPTH-1:0]      valid_vec;
   tkpq_pkg::op_type                    op;
   logic                                take, full, empty;

   logic [tkpq_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       strobe_ff;
   logic                       popped_ff, popped_in;
   tkpq_pkg::entry_type        out_ff, out_in;
   logic [1:0]                 status_ff, status_in;

   assign busy  = 1'b0;
   assign take  = start && !busy;
   assign full  = slot_vec[DEPTH-1].valid;
   assign empty = !slot_vec[0].valid;

   assign op.entry.id  = req_entry_id;
   assign op.entry.pri = req_primary_key;
   assign op.entry.sec = req_secondary_key;
   assign op.entry.hh  = req_arrival_hour;
   assign op.entry.mm  = req_arrival_minute;
   assign op.entry.ss  = req_arrival_second;
   // drop the insert when full, ignore the pop when empty
   assign op.ins = take && (req_command == tkpq_pkg::CMD_INSERT) && !full;
   assign op.pop = take && (req_command == tkpq_pkg::CMD_POP) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      tkpq_pkg::slot_type left_slot, right_slot;
      logic               left_before;

      if (i == 0) begin : g_head
         assign left_slot   = '0;
         assign left_before = 1'b0;
      end else begin : g_mid
         assign left_slot   = slot_vec[i-1];
         assign left_before = before_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_slot = '0;
      end else begin : g_body
         assign right_slot = slot_vec[i+1];
      end

      tkpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .left_slot   (left_slot),
         .left_before (left_before),
         .right_slot  (right_slot),
         .slot        (slot_vec[i]),
         .goes_ahead  (before_vec[i])
      );

      assign valid_vec[i] = slot_vec[i].valid;
   end

   always_comb begin
      count_in  = count_ff;
      popped_in = 1'b0;
      out_in    = '0;
      status_in = tkpq_pkg::STATUS_OK;
      case (req_command)
         tkpq_pkg::CMD_INSERT: begin
            if (full) begin
               status_in = tkpq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         tkpq_pkg::CMD_POP: begin
            if (empty) begin
               status_in = tkpq_pkg::STATUS_EMPTY;
            end else begin
               count_in  = count_ff - 1'b1;
               popped_in = 1'b1;
               out_in    = slot_vec[0].entry;
            end
         end
         default: begin
            status_in = tkpq_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= take;
         if (take) begin
            count_ff <= count_in;
         end
      end
      if (take) begin
         popped_ff <= popped_in;
         out_ff    <= out_in;
         status_ff <= status_in;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_popped_valid  = popped_ff;
   assign rsp_out_id        = out_ff.id;
   assign rsp_out_primary   = out_ff.pri;
   assign rsp_out_secondary = out_ff.sec;
   assign rsp_out_hour      = out_ff.hh;
   assign rsp_out_minute    = out_ff.mm;
   assign rsp_out_second    = out_ff.ss;
   assign rsp_occupancy     = tkpq_pkg::OCC_W'(count_ff);
   assign rsp_status        = status_ff;

   // count tracks the number of occupied cells
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("count does not match occupied cells");

   // occupied cells form a prefix from the head
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("occupied cells are not contiguous from the head");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_strobe)
      else $error("no result after request transfer");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == tkpq_pkg::STATUS_FULL) |->
         (int'(count_ff) == DEPTH && !rsp_popped_valid))
      else $error("insert dropped while not full");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_popped_valid) |-> rsp_status == tkpq_pkg::STATUS_OK)
      else $error("popped entry with error status");

endmodule

`default_nettype wire
